// ===== sv/matrix3_inverse_core_macros.svh =====
// Assertion helpers for the matrix inverse core checker.
`ifndef MATRIX3_INVERSE_CORE_MACROS_SVH
`define MATRIX3_INVERSE_CORE_MACROS_SVH

// a |-> b, disabled in reset
`define M3I_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("m3i check failed");

// a |=> b, disabled in reset
`define M3I_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("m3i check failed");

// a |=> b, checked also during reset
`define M3I_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("m3i check failed");

`endif

// ===== sv/m3inv_pkg.sv =====
`timescale 1ns / 1ps
package m3inv_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int THR_WIDTH  = 63;
   localparam logic [THR_WIDTH-1:0] THR_RESET = 63'd281475;

   // cofactor i = e[A]*e[D] - e[B]*e[C], entries indexed 3*row+col
   localparam int unsigned MINOR_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int unsigned MINOR_B [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int unsigned MINOR_C [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
   localparam int unsigned MINOR_D [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   // det = e0*adj0 + e1*adj3 + e2*adj6
   localparam int unsigned DET_COF [3] = '{0, 3, 6};

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] a_00;
      logic signed [DATA_WIDTH-1:0] a_01;
      logic signed [DATA_WIDTH-1:0] a_02;
      logic signed [DATA_WIDTH-1:0] a_10;
      logic signed [DATA_WIDTH-1:0] a_11;
      logic signed [DATA_WIDTH-1:0] a_12;
      logic signed [DATA_WIDTH-1:0] a_20;
      logic signed [DATA_WIDTH-1:0] a_21;
      logic signed [DATA_WIDTH-1:0] a_22;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] inv_00;
      logic signed [DATA_WIDTH-1:0] inv_01;
      logic signed [DATA_WIDTH-1:0] inv_02;
      logic signed [DATA_WIDTH-1:0] inv_10;
      logic signed [DATA_WIDTH-1:0] inv_11;
      logic signed [DATA_WIDTH-1:0] inv_12;
      logic signed [DATA_WIDTH-1:0] inv_20;
      logic signed [DATA_WIDTH-1:0] inv_21;
      logic signed [DATA_WIDTH-1:0] inv_22;
      logic                         singular;
   } rsp_type;

endpackage

// ===== sv/matrix3_inverse_core.sv =====
`timescale 1ns / 1ps
// 3x3 fixed-point matrix inverse (adjugate / determinant), fully pipelined: one matrix
// may enter every cycle while the result side is not stalled; each result passes through
// the one-bit-per-stage restoring dividers (33 quotient stages, nine lanes) that follow
// six stages of cofactor, determinant and numerator setup. A stall on a valid result
// freezes the whole pipeline; req_stall then follows rsp_stall. The threshold register may
// be written at any time the block is idle and is always ready.
module matrix3_inverse_core import m3inv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [THR_WIDTH-1:0] csr_data
);

   localparam int DW   = DATA_WIDTH;
   localparam int PW   = 2 * DW;
   localparam int CW   = 2 * DW + 1;
   localparam int HW   = 2 * DW + 1;
   localparam int DETW = 3 * DW + 3;
   localparam int QB   = DW + 1;
   localparam int NW0  = CW + 2 * FRAC_BITS + 1;
   localparam int NW   = (NW0 > DETW ? NW0 : DETW) + 1;
   localparam int RW   = NW + QB + 2;
   localparam logic [QB-1:0] QPOS = QB'((65'd1 << (DW - 1)) - 65'd1);
   localparam logic [QB-1:0] QNEG = QB'(65'd1 << (DW - 1));
   localparam logic [DW-1:0] OUT_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] OUT_MIN = {1'b1, {(DW-1){1'b0}}};

   logic en;
   logic [THR_WIDTH-1:0] thr_ff;
   logic [5:0] v_ff;

   logic signed [DW-1:0]   e_in   [9];
   logic signed [DW-1:0]   e_ff   [9];
   logic signed [PW-1:0]   pa_ff  [9];
   logic signed [PW-1:0]   pb_ff  [9];
   logic signed [DW-1:0]   e1_ff  [3];
   logic signed [CW-1:0]   adj_ff [9];
   logic signed [DW-1:0]   e2_ff  [3];
   logic signed [HW-1:0]   pl_ff  [3];
   logic signed [HW-1:0]   ph_ff  [3];
   logic signed [CW-1:0]   adj3_ff[9];
   logic signed [DETW-1:0] det_ff;
   logic signed [CW-1:0]   adj4_ff[9];
   logic [DETW-1:0]        adet;
   logic [RW-1:0]          num_ff [9];
   logic [RW-1:0]          twod_ff;
   logic [8:0]             neg_ff;
   logic                   sing_ff;

   logic [RW-1:0] rem_ff  [QB+1][9];
   logic [QB-1:0] q_ff    [QB+1][9];
   logic [8:0]    ovf_ff  [QB+1];
   logic [8:0]    dneg_ff [QB+1];
   logic [RW-1:0] dtwod_ff[QB+1];
   logic          dsing_ff[QB+1];
   logic          vd_ff   [QB+1];

   logic [DW-1:0] res_in [9];
   logic [DW-1:0] res_ff [9];
   logic          rsing_ff;
   logic          rsp_valid_ff;

   assign en        = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j <= QB; j++) vd_ff[j] <= 1'b0;
      end else if (en) begin
         v_ff         <= {v_ff[4:0], req_valid};
         vd_ff[0]     <= v_ff[5];
         for (int j = 1; j <= QB; j++) vd_ff[j] <= vd_ff[j-1];
         rsp_valid_ff <= vd_ff[QB];
      end
   end

   always_comb begin
      e_in[0] = req_data.a_00;
      e_in[1] = req_data.a_01;
      e_in[2] = req_data.a_02;
      e_in[3] = req_data.a_10;
      e_in[4] = req_data.a_11;
      e_in[5] = req_data.a_12;
      e_in[6] = req_data.a_20;
      e_in[7] = req_data.a_21;
      e_in[8] = req_data.a_22;
   end

   // stages 0..4: capture, minor products, cofactors, det partial products, det
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) begin
            e_ff[i]    <= e_in[i];
            pa_ff[i]   <= PW'(e_ff[MINOR_A[i]]) * PW'(e_ff[MINOR_D[i]]);
            pb_ff[i]   <= PW'(e_ff[MINOR_B[i]]) * PW'(e_ff[MINOR_C[i]]);
            adj_ff[i]  <= CW'(pa_ff[i]) - CW'(pb_ff[i]);
            adj3_ff[i] <= adj_ff[i];
            adj4_ff[i] <= adj3_ff[i];
         end
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= e_ff[k];
            e2_ff[k] <= e1_ff[k];
            // split cofactor into unsigned low half and signed high part
            pl_ff[k] <= HW'(e2_ff[k]) * HW'($signed({1'b0, adj_ff[DET_COF[k]][DW-1:0]}));
            ph_ff[k] <= HW'(e2_ff[k]) * HW'($signed(adj_ff[DET_COF[k]][CW-1:DW]));
         end
         det_ff <= ((DETW'(ph_ff[0]) <<< DW) + DETW'(pl_ff[0]))
                 + ((DETW'(ph_ff[1]) <<< DW) + DETW'(pl_ff[1]))
                 + ((DETW'(ph_ff[2]) <<< DW) + DETW'(pl_ff[2]));
      end
   end

   assign adet = det_ff[DETW-1] ? (~det_ff + 1'b1) : det_ff;

   // stage 5: magnitudes, rounding numerator, singular test
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) begin
            logic [CW-1:0] aadj;
            aadj = adj4_ff[i][CW-1] ? (~adj4_ff[i] + 1'b1) : adj4_ff[i];
            num_ff[i] <= (RW'(aadj) << (2 * FRAC_BITS + 1)) + RW'(adet);
            neg_ff[i] <= adj4_ff[i][CW-1] ^ det_ff[DETW-1];
         end
         twod_ff <= RW'(adet) << 1;
         sing_ff <= RW'(adet) <= RW'(thr_ff);
      end
   end

   // stage 6: overflow check, divider entry
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) begin
            rem_ff[0][i] <= num_ff[i];
            q_ff[0][i]   <= '0;
            ovf_ff[0][i] <= num_ff[i] >= (twod_ff << QB);
         end
         dneg_ff[0]  <= neg_ff;
         dtwod_ff[0] <= twod_ff;
         dsing_ff[0] <= sing_ff;
      end
   end

   // one quotient bit per stage, MSB first
   for (genvar j = 1; j <= QB; j++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 9; i++) begin
               if (rem_ff[j-1][i] >= (dtwod_ff[j-1] << (QB - j))) begin
                  rem_ff[j][i] <= rem_ff[j-1][i] - (dtwod_ff[j-1] << (QB - j));
                  q_ff[j][i]   <= {q_ff[j-1][i][QB-2:0], 1'b1};
               end else begin
                  rem_ff[j][i] <= rem_ff[j-1][i];
                  q_ff[j][i]   <= {q_ff[j-1][i][QB-2:0], 1'b0};
               end
            end
            ovf_ff[j]   <= ovf_ff[j-1];
            dneg_ff[j]  <= dneg_ff[j-1];
            dtwod_ff[j] <= dtwod_ff[j-1];
            dsing_ff[j] <= dsing_ff[j-1];
         end
      end
   end

   // sign and saturate, zero when singular
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         if (dsing_ff[QB]) begin
            res_in[i] = '0;
         end else if (!dneg_ff[QB][i]) begin
            res_in[i] = (ovf_ff[QB][i] || q_ff[QB][i] > QPOS) ? OUT_MAX
                                                              : q_ff[QB][i][DW-1:0];
         end else begin
            res_in[i] = (ovf_ff[QB][i] || q_ff[QB][i] > QNEG) ? OUT_MIN
                                                              : (~q_ff[QB][i][DW-1:0] + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) res_ff[i] <= res_in[i];
         rsing_ff <= dsing_ff[QB];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data.inv_00   = res_ff[0];
   assign rsp_data.inv_01   = res_ff[1];
   assign rsp_data.inv_02   = res_ff[2];
   assign rsp_data.inv_10   = res_ff[3];
   assign rsp_data.inv_11   = res_ff[4];
   assign rsp_data.inv_12   = res_ff[5];
   assign rsp_data.inv_20   = res_ff[6];
   assign rsp_data.inv_21   = res_ff[7];
   assign rsp_data.inv_22   = res_ff[8];
   assign rsp_data.singular = rsing_ff;

endmodule

// ===== sv/m3inv_checker.sv =====
`timescale 1ns / 1ps
`include "matrix3_inverse_core_macros.svh"
module m3inv_checker import m3inv_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `M3I_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `M3I_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   // all nine inverse lanes sit above the singular bit
   `M3I_ASSERT_IMPLY(a_sing_zero, clock, reset, rsp_valid && rsp_data.singular, rsp_data[9*DATA_WIDTH:1] == '0)
   `M3I_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind matrix3_inverse_core m3inv_checker u_m3inv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
